[design/fpba_pkg.sv]
package fpba_pkg;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_CHARGE = 3'b100
  } state_t;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [1:0] FIT_MODE_RESET    = MODE_FIRST;
  localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

[design/fpba_ram.sv]
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/fit_policy_block_allocator_unit.sv]
// Load transaction: written to the free-size RAM in the cycle it is accepted, no result.
// Request transaction: an accept, one RAM read per active block (block_count, capped
// at NUM_BLOCKS), a read-latency step, a drain step and a charge/write-back step that waits
// for a free result slot. The single RAM read port serialises the block reads.
// Reset (rst, synchronous, active high) clears the per-block valid bits, so every free
// size reads as zero, and sets fit_mode to first fit and block_count to 16.
module fit_policy_block_allocator_unit
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // load_index[3:0], size_value[19:4], zero pad
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // chosen_block[3:0], zero pad
  output logic        m_tuser,   // granted
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  state_t state;

  logic [1:0] fit_mode;
  logic [4:0] block_count;

  logic [NUM_BLOCKS-1:0] vld;
  logic [CW-1:0]         active;
  logic [CW-1:0]         cnt;
  logic                  cmp_v;
  logic [AW-1:0]         cmp_idx;
  logic                  rd_vld;
  logic [SIZE_BITS-1:0]  req_size;
  logic                  found;
  logic [AW-1:0]         pick;
  logic [SIZE_BITS-1:0]  best_val;

  logic                  in_acc;
  logic [3:0]            in_idx;
  logic [SIZE_BITS-1:0]  in_size;
  logic                  load_ok;
  logic                  issue;
  logic [SIZE_BITS-1:0]  rdata;
  logic [SIZE_BITS-1:0]  cur;
  logic                  take;
  logic                  out_free;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [SIZE_BITS-1:0]  wdata;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_idx   = s_tdata[3:0];
  assign in_size  = SIZE_BITS'(s_tdata[19:4]);
  assign load_ok  = ({28'd0, in_idx} < NUM_BLOCKS);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if ({27'd0, block_count} > NUM_BLOCKS) begin
      active = CW'(NUM_BLOCKS);
    end else begin
      active = CW'(block_count);
    end
  end

  assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? {27'd0, block_count} : {30'd0, fit_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode    <= FIT_MODE_RESET;
      block_count <= BLOCK_COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_FIT_MODE) begin
        fit_mode <= pwdata[1:0];
      end else begin
        block_count <= pwdata[4:0];
      end
    end
  end

  assign issue = (state == ST_SCAN) && (cnt != active);
  assign cur   = rd_vld ? rdata : '0;

  // mode 3 falls through as first fit
  always_comb begin
    take = 1'b0;
    if (cmp_v && (cur >= req_size)) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_mode == MODE_BEST) begin
        take = (cur < best_val);
      end else if (fit_mode == MODE_WORST) begin
        take = (cur > best_val);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(in_idx);
    wdata = in_size;
    if (state == ST_CHARGE) begin
      we    = found && out_free;
      waddr = pick;
      wdata = best_val - req_size;
    end else if (in_acc && (s_tuser == KIND_LOAD)) begin
      we = load_ok;
    end
  end

  fpba_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_BLOCKS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cmp_v    <= 1'b0;
      m_tvalid <= 1'b0;
      found    <= 1'b0;
      cnt      <= '0;
    end else begin
      cmp_v <= issue;
      if ((state == ST_CHARGE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (s_tuser == KIND_REQUEST)) begin
            state <= ST_SCAN;
            cnt   <= '0;
            found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (take) begin
            found <= 1'b1;
          end
          if ((cnt == active) && !cmp_v) begin
            state <= ST_CHARGE;
          end
        end
        ST_CHARGE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_size <= in_size;
    end
    cmp_idx <= cnt[AW-1:0];
    rd_vld  <= vld[cnt[AW-1:0]];
    if (take) begin
      pick     <= cmp_idx;
      best_val <= cur;
    end
    if ((state == ST_CHARGE) && out_free) begin
      m_tuser <= found;
      m_tdata <= found ? {4'd0, 4'(pick)} : 8'd0;
    end
  end

endmodule

[design/fpba_checker.sv]
module fpba_checker
  import fpba_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("refused request carries nonzero block");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_REQUEST) |=> !s_tready)
    else $error("input taken during request scan");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("load transaction produced a result");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (.*);
